// ===== hw/rtl/arbi_pkg.sv =====
`timescale 1ns / 1ps
package arbi_pkg;

   localparam int SEG_W       = 25;
   localparam int LC_W        = 5;
   localparam int BN_W        = 30;
   localparam int WORD_W      = 64;
   localparam int HALF_W      = 32;
   localparam int IDX_W       = 30;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 25;

   localparam int SLICE_COUNT_DEFAULT = 4;

   localparam logic [SEG_W-1:0]  SEG_RESET = SEG_W'(262144);
   localparam logic [LC_W-1:0]   LC_RESET  = LC_W'(4);
   localparam logic [HALF_W-1:0] ALL_ONES  = 32'hFFFF_FFFF;

   localparam logic [CSR_IDX_W-1:0] CSR_SEG_LEN    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LANE_COUNT = 1'b1;

endpackage

// ===== hw/rtl/arbi_if.sv =====
`timescale 1ns / 1ps
interface arbi_req_if;
   logic                             valid;
   logic                             ready;
   logic [arbi_pkg::BN_W-1:0]        block_number;
   logic [arbi_pkg::WORD_W-1:0]      prev_opening_word;
   logic                             later_pass;

   modport source (output valid, block_number, prev_opening_word, later_pass, input ready);
   modport sink   (input valid, block_number, prev_opening_word, later_pass, output ready);
endinterface

interface arbi_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [arbi_pkg::IDX_W-1:0]       prior_index;
   logic [arbi_pkg::IDX_W-1:0]       ref_block_index;

   modport source (output valid, prior_index, ref_block_index, input ready);
   modport sink   (input valid, prior_index, ref_block_index, output ready);
endinterface

// ===== hw/rtl/argon2_ref_block_index.sv =====
`timescale 1ns / 1ps
// Argon2d-style reference block index generator. Each item carries a global block
// number, the first word of the previous block and a later-pass flag; the block
// returns the previous block's index in its lane and the referenced block's index.
// The block takes one item per clock while the result channel does not stall. A
// 32-stage bit-per-stage divider splits the block number by the lane length (and,
// in parallel, reduces the high word by the lane count), four stages find slice
// and position, build the reference area and do the two 32x32 multiplies, a
// 33-stage divider reduces the reference offset modulo the lane
// length, and one output register holds the result. Any stall of the result channel
// holds the whole pipeline; the input is ready whenever the output register is empty
// or being taken. Write the segment length and lane count only while no item is in
// flight.
module argon2_ref_block_index #(
   parameter int SLICE_COUNT = arbi_pkg::SLICE_COUNT_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   arbi_req_if.sink                        req_bus,
   arbi_rsp_if.source                      rsp_bus,
   input  logic                            csr_we,
   input  logic [arbi_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [arbi_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int SEG_W = arbi_pkg::SEG_W;
   localparam int SLW   = $clog2(SLICE_COUNT);
   localparam int LLW   = SEG_W + SLW;
   localparam int HW    = arbi_pkg::HALF_W;
   localparam int IW    = arbi_pkg::IDX_W;
   localparam int LCW   = arbi_pkg::LC_W;
   localparam int MW    = LLW + IW;

   // configuration
   logic [SEG_W-1:0] seg_ff;
   logic [LCW-1:0]   lc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff <= arbi_pkg::SEG_RESET;
         lc_ff  <= arbi_pkg::LC_RESET;
      end else if (csr_we) begin
         case (csr_index)
            arbi_pkg::CSR_SEG_LEN:    seg_ff <= csr_wdata[SEG_W-1:0];
            arbi_pkg::CSR_LANE_COUNT: lc_ff  <= csr_wdata[LCW-1:0];
            default: ;
         endcase
      end
   end

   logic [LLW-1:0] lane_len;
   logic [LLW-1:0] mult [SLICE_COUNT];

   assign lane_len = LLW'(seg_ff) * LLW'(SLICE_COUNT);
   for (genvar k = 0; k < SLICE_COUNT; k++) begin : g_mult
      assign mult[k] = LLW'(seg_ff) * LLW'(k);
   end

   logic en;
   logic out_valid_ff;
   assign en            = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = en;

   logic req_take;
   assign req_take = req_bus.valid && req_bus.ready;

   // dividers: block number by lane length, high word by lane count
   logic            d1_valid, d2_valid;
   logic [HW-1:0]   d1_quo, d2_quo;
   logic [LLW-1:0]  d1_rem;
   logic [LCW-1:0]  d2_rem;
   logic [IW+HW-1:0] d1_side;
   logic            d2_side;

   arbi_div_pipe #(.DW(HW), .VW(LLW), .SW(IW + HW)) u_div_lane (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_take),
      .in_num    (HW'(req_bus.block_number)),
      .in_side   ({req_bus.block_number, req_bus.prev_opening_word[HW-1:0]}),
      .divisor   (lane_len),
      .out_valid (d1_valid),
      .out_quo   (d1_quo),
      .out_rem   (d1_rem),
      .out_side  (d1_side)
   );

   arbi_div_pipe #(.DW(HW), .VW(LCW), .SW(1)) u_div_lane_sel (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_take),
      .in_num    (req_bus.prev_opening_word[2*HW-1:HW]),
      .in_side   (req_bus.later_pass),
      .divisor   (lc_ff),
      .out_valid (d2_valid),
      .out_quo   (d2_quo),
      .out_rem   (d2_rem),
      .out_side  (d2_side)
   );

   // stage 1: slice, position, reference lane, previous index, squaring
   logic [IW-1:0]  d1_ij, d1_lane;
   logic [HW-1:0]  d1_rnd, ij_ext;
   logic [SLW-1:0] slice_c;
   logic [SEG_W-1:0] pos_c;
   logic [IW-1:0]  rl_c;
   logic [IW-1:0]  rl_mod;
   logic [2*HW-1:0] sq_full;
   logic [HW-1:0]  prev_full;

   assign d1_ij   = d1_side[IW+HW-1:HW];
   assign d1_rnd  = d1_side[HW-1:0];
   assign d1_lane = d1_quo[IW-1:0] | IW'(d2_quo & '0);
   assign ij_ext  = HW'(d1_ij);

   always_comb begin
      slice_c = '0;
      for (int k = 1; k < SLICE_COUNT; k++) begin
         if (d1_rem >= mult[k]) slice_c = SLW'(k);
      end
   end

   assign pos_c     = SEG_W'(d1_rem - mult[slice_c]);
   assign rl_mod    = (lc_ff == '0) ? '0 : IW'(d2_rem);
   assign rl_c      = (slice_c == '0) ? d1_lane : rl_mod;
   assign prev_full = (d1_rem == '0) ? ij_ext + HW'(lane_len) - HW'(1) : ij_ext - HW'(1);
   assign sq_full   = (2*HW)'(d1_rnd) * (2*HW)'(d1_rnd);

   logic             s1_valid_ff;
   logic [SLW-1:0]   s1_slice_ff;
   logic [SEG_W-1:0] s1_pos_ff;
   logic [LLW-1:0]   s1_rem_ff;
   logic [IW-1:0]    s1_rl_ff;
   logic             s1_same_ff;
   logic             s1_later_ff;
   logic [IW-1:0]    s1_prev_ff;
   logic [HW-1:0]    s1_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= d1_valid && d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_slice_ff <= slice_c;
         s1_pos_ff   <= pos_c;
         s1_rem_ff   <= d1_rem;
         s1_rl_ff    <= rl_c;
         s1_same_ff  <= rl_c == d1_lane;
         s1_later_ff <= d2_side;
         s1_prev_ff  <= prev_full[IW-1:0];
         s1_sq_ff    <= sq_full[2*HW-1:HW];
      end
   end

   // stage 2: reference area and start
   logic [HW-1:0] pos_adj, area_c, start_c;
   logic [SLW-1:0] slice_next;

   assign pos_adj    = (s1_pos_ff == '0) ? arbi_pkg::ALL_ONES : '0;
   assign slice_next = s1_slice_ff + SLW'(1);

   always_comb begin
      if (!s1_later_ff) begin
         if (s1_slice_ff == '0) area_c = HW'(s1_pos_ff) - HW'(1);
         else if (s1_same_ff)   area_c = HW'(s1_rem_ff) - HW'(1);
         else                   area_c = HW'(mult[s1_slice_ff]) + pos_adj;
      end else begin
         area_c = HW'(lane_len) - HW'(seg_ff)
                  + (s1_same_ff ? HW'(s1_pos_ff) - HW'(1) : pos_adj);
      end
   end

   assign start_c = (s1_later_ff && s1_slice_ff != SLW'(SLICE_COUNT - 1))
                    ? HW'(mult[slice_next]) : '0;

   logic          s2_valid_ff;
   logic [HW-1:0] s2_area_ff, s2_start_ff, s2_sq_ff;
   logic [IW-1:0] s2_rl_ff, s2_prev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_area_ff  <= area_c;
         s2_start_ff <= start_c;
         s2_sq_ff    <= s1_sq_ff;
         s2_rl_ff    <= s1_rl_ff;
         s2_prev_ff  <= s1_prev_ff;
      end
   end

   // stage 3: area times squared value, lane base
   logic [2*HW-1:0] prod_full;
   logic [MW-1:0]   base_full;

   assign prod_full = (2*HW)'(s2_area_ff) * (2*HW)'(s2_sq_ff);
   assign base_full = MW'(lane_len) * MW'(s2_rl_ff);

   logic          s3_valid_ff;
   logic [HW-1:0] s3_prod_ff, s3_base_ff, s3_area_ff, s3_start_ff;
   logic [IW-1:0] s3_prev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_prod_ff  <= prod_full[2*HW-1:HW];
         s3_base_ff  <= base_full[HW-1:0];
         s3_area_ff  <= s2_area_ff;
         s3_start_ff <= s2_start_ff;
         s3_prev_ff  <= s2_prev_ff;
      end
   end

   // stage 4: offset from start of the reference area
   logic [HW-1:0] area_m1;
   logic [HW:0]   sum_c;

   assign area_m1 = s3_area_ff - HW'(1);
   assign sum_c   = {1'b0, area_m1} - {1'b0, s3_prod_ff} + {1'b0, s3_start_ff};

   logic          s4_valid_ff;
   logic [HW:0]   s4_sum_ff;
   logic [HW-1:0] s4_base_ff;
   logic [IW-1:0] s4_prev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_sum_ff  <= sum_c;
         s4_base_ff <= s3_base_ff;
         s4_prev_ff <= s3_prev_ff;
      end
   end

   // wrap offset into the lane
   logic              d3_valid;
   logic [HW:0]       d3_quo;
   logic [LLW-1:0]    d3_rem;
   logic [HW+IW-1:0]  d3_side;

   arbi_div_pipe #(.DW(HW + 1), .VW(LLW), .SW(HW + IW)) u_div_wrap (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s4_valid_ff),
      .in_num    (s4_sum_ff),
      .in_side   ({s4_base_ff, s4_prev_ff}),
      .divisor   (lane_len),
      .out_valid (d3_valid),
      .out_quo   (d3_quo),
      .out_rem   (d3_rem),
      .out_side  (d3_side)
   );

   logic [HW-1:0] ref_full;
   logic          seg_zero;

   assign ref_full = d3_side[HW+IW-1:IW] + HW'(d3_rem) + HW'(d3_quo & '0);
   assign seg_zero = seg_ff == '0;

   logic [IW-1:0] out_prev_ff, out_ref_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= d3_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_prev_ff <= seg_zero ? '0 : d3_side[IW-1:0];
         out_ref_ff  <= seg_zero ? '0 : ref_full[IW-1:0];
      end
   end

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.prior_index     = out_prev_ff;
   assign rsp_bus.ref_block_index = out_ref_ff;

endmodule

// ===== hw/rtl/arbi_div_pipe.sv =====
`timescale 1ns / 1ps
module arbi_div_pipe #(
   parameter int DW = 32,
   parameter int VW = 28,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [DW-1:0] in_num,
   input  logic [SW-1:0] in_side,
   input  logic [VW-1:0] divisor,
   output logic          out_valid,
   output logic [DW-1:0] out_quo,
   output logic [VW-1:0] out_rem,
   output logic [SW-1:0] out_side
);

   logic [DW-1:0] valid_ff, valid_in;
   logic [DW-1:0] num_ff  [DW];
   logic [DW-1:0] num_in  [DW];
   logic [VW-1:0] rem_ff  [DW];
   logic [VW-1:0] rem_in  [DW];
   logic [SW-1:0] side_ff [DW];
   logic [SW-1:0] side_in [DW];

   // one quotient bit per stage, restoring form
   for (genvar s = 0; s < DW; s++) begin : g_stage
      logic [DW-1:0] num_prev;
      logic [VW-1:0] rem_prev;
      logic [VW:0]   trial;
      logic [VW:0]   diff;
      logic          ge;

      if (s == 0) begin : g_first
         assign num_prev    = in_num;
         assign rem_prev    = '0;
         assign valid_in[s] = in_valid;
         assign side_in[s]  = in_side;
      end else begin : g_next
         assign num_prev    = num_ff[s-1];
         assign rem_prev    = rem_ff[s-1];
         assign valid_in[s] = valid_ff[s-1];
         assign side_in[s]  = side_ff[s-1];
      end

      assign trial     = {rem_prev, num_prev[DW-1]};
      assign diff      = trial - {1'b0, divisor};
      assign ge        = trial >= {1'b0, divisor};
      assign rem_in[s] = ge ? diff[VW-1:0] : trial[VW-1:0];
      assign num_in[s] = {num_prev[DW-2:0], ge};

      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[s]  <= num_in[s];
            rem_ff[s]  <= rem_in[s];
            side_ff[s] <= side_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   assign out_valid = valid_ff[DW-1];
   assign out_quo   = num_ff[DW-1];
   assign out_rem   = rem_ff[DW-1];
   assign out_side  = side_ff[DW-1];

endmodule

// ===== hw/rtl/arbi_checker.sv =====
`timescale 1ns / 1ps
module arbi_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [arbi_pkg::IDX_W-1:0] rsp_prior_index,
   input logic [arbi_pkg::IDX_W-1:0] rsp_ref_block_index
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("input stalled while output free");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped under stall");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_prior_index) && $stable(rsp_ref_block_index)))
      else $error("result changed under stall");

endmodule

bind argon2_ref_block_index arbi_checker u_arbi_checker (
   .clock               (clock),
   .reset               (reset),
   .req_ready           (req_bus.ready),
   .rsp_valid           (rsp_bus.valid),
   .rsp_ready           (rsp_bus.ready),
   .rsp_prior_index     (rsp_bus.prior_index),
   .rsp_ref_block_index (rsp_bus.ref_block_index)
);
